### rtl/unordered_set_table_macros.svh
// assertion macros for the unordered set table checker
`ifndef UNORDERED_SET_TABLE_MACROS_SVH
`define UNORDERED_SET_TABLE_MACROS_SVH

// checked only while out of reset
`define UST_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define UST_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/ust_pkg.sv
// shared constants, codes and types of the unordered set table
`default_nettype none

package ust_pkg;

    localparam int CAPACITY   = 64;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_REM = 2'd1;
    localparam logic [1:0] REQ_GET = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOCHANGE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADIDX   = 2'd3;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [VALUE_BITS-1:0] wdata;
        logic [ADDR_W-1:0]     raddr;
    } ust_ram_req_t;

    typedef struct packed {
        logic                  valid;
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] rdata;
        logic [CNT_W-1:0]      count;
    } ust_res_t;

endpackage

`default_nettype wire

### rtl/ust_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ust_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/ust_ctrl.sv
// request sequencer: linear search with one shared compare, swap removal
`default_nettype none

module ust_ctrl
    import ust_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [1:0]            req_type,
    input  wire logic [VALUE_BITS-1:0] elem_value,
    input  wire logic [CNT_W-1:0]      entry_index,
    input  wire logic [VALUE_BITS-1:0] rd_data,
    output ust_ram_req_t               ram_req,
    output ust_res_t                   res,
    output logic                       busy
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_LAST   = 2'd2;
    localparam logic [1:0] S_GET    = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [1:0]            req_reg, req_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;

    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] idx_m1;
    logic             hit;
    logic             at_last;
    logic             full;

    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_m1   = entry_index - CNT_W'(1);
    assign hit      = (rd_data == val_reg);
    assign at_last  = (CNT_W'(pos_reg) == count_m1);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        ram_req    = '0;
        res        = '0;
        res.status = ST_DONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    val_next = elem_value;
                    unique case (req_type)
                        REQ_ADD, REQ_REM:
                        begin
                            if (count_reg == '0)
                            begin
                                res.valid = 1'b1;
                                if (req_type == REQ_ADD)
                                begin
                                    ram_req.we    = 1'b1;
                                    ram_req.waddr = '0;
                                    ram_req.wdata = elem_value;
                                    count_next    = CNT_W'(1);
                                end
                                else
                                begin
                                    res.status = ST_NOCHANGE;
                                end
                            end
                            else
                            begin
                                pos_next      = '0;
                                ram_req.raddr = '0;
                                state_next    = S_SEARCH;
                            end
                        end
                        REQ_GET:
                        begin
                            if (entry_index == '0 || entry_index > count_reg)
                            begin
                                res.valid  = 1'b1;
                                res.status = ST_BADIDX;
                            end
                            else
                            begin
                                ram_req.raddr = idx_m1[ADDR_W-1:0];
                                state_next    = S_GET;
                            end
                        end
                        default:
                        begin
                            res.valid  = 1'b1;
                            res.status = ST_BADIDX;
                        end
                    endcase
                end
            end
            S_SEARCH:
            begin
                priority if (hit)
                begin
                    if (req_reg == REQ_ADD)
                    begin
                        res.valid  = 1'b1;
                        res.status = ST_NOCHANGE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ram_req.raddr = count_m1[ADDR_W-1:0];
                        state_next    = S_LAST;
                    end
                end
                else if (at_last)
                begin
                    res.valid  = 1'b1;
                    state_next = S_IDLE;
                    if (req_reg != REQ_ADD)
                    begin
                        res.status = ST_NOCHANGE;
                    end
                    else if (full)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = count_reg[ADDR_W-1:0];
                        ram_req.wdata = val_reg;
                        count_next    = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    pos_next      = pos_reg + ADDR_W'(1);
                    ram_req.raddr = pos_next;
                end
            end
            S_LAST:
            begin
                // move the last entry into the hole
                ram_req.we    = 1'b1;
                ram_req.waddr = pos_reg;
                ram_req.wdata = rd_data;
                count_next    = count_m1;
                res.valid     = 1'b1;
                state_next    = S_IDLE;
            end
            S_GET:
            begin
                res.valid  = 1'b1;
                res.rdata  = rd_data;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        val_reg <= val_next;
        pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

### rtl/unordered_set_table.sv
// top level of the unordered set table: sequencer, entry ram, result register
//
//  channel   signals                                   handshake
//  request   req_type, elem_value, entry_index         start, taken when busy is low
//  result    status, read_value, element_count         done, one cycle, no stall
//
// add and remove scan the held entries one per cycle through the entry ram read port;
// done follows the scan through the result register, with a move step added for a remove hit
// get reads the indexed entry before done; an empty table or a bad request is answered from idle
// reset clears the count and the sequencer; entries need no clearing
// busy stays high until the last sequencer step; results cannot be held off
`default_nettype none

module unordered_set_table
    import ust_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            req_type,
    input  wire logic [VALUE_BITS-1:0] elem_value,
    input  wire logic [CNT_W-1:0]      entry_index,
    output logic                       done,
    output logic [1:0]                 status,
    output logic [VALUE_BITS-1:0]      read_value,
    output logic [CNT_W-1:0]           element_count
);

    ust_ram_req_t          ram_req;
    ust_res_t              res;
    logic [VALUE_BITS-1:0] rd_data;

    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [VALUE_BITS-1:0] read_value_reg;
    logic [CNT_W-1:0]      count_out_reg;

    ust_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req_type    (req_type),
        .elem_value  (elem_value),
        .entry_index (entry_index),
        .rd_data     (rd_data),
        .ram_req     (ram_req),
        .res         (res),
        .busy        (busy)
    );

    ust_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            status_reg     <= res.status;
            read_value_reg <= res.rdata;
            count_out_reg  <= res.count;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign element_count = count_out_reg;

endmodule

`default_nettype wire

### rtl/ust_checker.sv
// port-level checker for the unordered set table, bound to the top level
`default_nettype none

`include "unordered_set_table_macros.svh"

module ust_checker
    import ust_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic                  done,
    input wire logic [1:0]            status,
    input wire logic [VALUE_BITS-1:0] read_value,
    input wire logic [CNT_W-1:0]      element_count
);

    logic bad_rsp;

    assign bad_rsp = done && (status != ST_DONE);

    `UST_ASSERT_ANY(a_reset_quiet, !rst_n |=> (!done && !busy), "done or busy during reset")
    `UST_ASSERT_CLK(a_done_has_cause, done |-> $past(busy || start), "done without a request")
    `UST_ASSERT_CLK(a_no_done_while_busy, busy |-> !done, "done while still busy")
    `UST_ASSERT_CLK(a_count_bound, done |-> (element_count <= CNT_W'(CAPACITY)), "count too large")
    `UST_ASSERT_CLK(a_value_only_on_done, bad_rsp |-> (read_value == '0), "stray read value")

endmodule

bind unordered_set_table ust_checker u_ust_checker (.*);

`default_nettype wire
